/* rtl/arbl_pkg.sv */
// ----------------------------------------------------------------------------
// arbl_pkg
// shared widths, codes and reciprocal constants for the battery level block
// ----------------------------------------------------------------------------
package arbl_pkg;

    // number of entries in each ring
    localparam int DEPTH = 8;

    localparam int SAMPLE_W  = 11;
    localparam int HYST_W    = 8;
    localparam int PTR_W     = 8;
    localparam int CHAN_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;

    // ring slot index and shared memory geometry (battery ring low, knob ring high)
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RAM_D    = 2 * DEPTH;
    localparam int RAM_AW   = $clog2(RAM_D);

    // running sum of the battery ring and floor(sum / DEPTH) by reciprocal
    localparam int SUM_W       = SAMPLE_W + $clog2(DEPTH);
    localparam int RECIP_SHIFT = SUM_W + $clog2(DEPTH);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLENTY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST   = 2'd3;

    localparam logic [SAMPLE_W-1:0] EMPTY_RST  = 11'd600;
    localparam logic [SAMPLE_W-1:0] LOW_RST    = 11'd700;
    localparam logic [SAMPLE_W-1:0] PLENTY_RST = 11'd800;
    localparam logic [HYST_W-1:0]   HYST_RST   = 8'd16;

    // battery status codes
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LOW    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PLENTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // next channel codes
    localparam logic [CHAN_W-1:0] CH_NONE    = 2'd0;
    localparam logic [CHAN_W-1:0] CH_BATTERY = 2'd1;
    localparam logic [CHAN_W-1:0] CH_KNOB    = 2'd2;

endpackage

/* rtl/adc_ring_average_battery_level.sv */
// ----------------------------------------------------------------------------
// adc_ring_average_battery_level
// converter sample routing into two rings and hysteretic battery classifier
// ----------------------------------------------------------------------------
// A conversion transfer (mode 0) forms high_byte*4 + low_byte and stores it in
// the battery ring or, on alternate events while adjusting, in the knob ring;
// an evaluate transfer (mode 1) reports floor(sum / DEPTH) of the battery ring
// and updates the four-level status with hysteresis. Both rings share one
// ram with registered read. A running sum of the battery ring is kept by
// reading the slot being overwritten and applying new minus old, so the
// average needs no walk over the ring; a two stage reciprocal multiply does
// the divide. One item is worked on at a time and the input stalls until it
// is done: a conversion goes through the ring write, on the battery ring after
// the read of the slot being overwritten, to the result register; an
// evaluate through the two multiply stages, then the classifier that loads
// the status. The next input transfer is taken the cycle after the result
// register loads.
// The result sits in an output register, so the next input transfer is taken
// while a result waits; a finished item holds in its last step only while the
// previous result has not yet been taken. Ring slots never written read
// as zero through per-slot valid bits on the battery ring, so no clearing
// pass is needed after reset. Configuration writes are taken any cycle.
// ----------------------------------------------------------------------------
module adc_ring_average_battery_level (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // input item channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [7:0]                        i_high_byte,
    input  logic [7:0]                        i_low_byte,
    input  logic                              i_adjusting,

    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [arbl_pkg::SAMPLE_W-1:0]     o_sample_value,
    output logic                              o_went_to_knob,
    output logic [arbl_pkg::CHAN_W-1:0]       o_next_channel,
    output logic [arbl_pkg::SAMPLE_W-1:0]     o_battery_average,
    output logic [arbl_pkg::STATUS_W-1:0]     o_battery_status,

    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [arbl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [arbl_pkg::CFG_W-1:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BATT_WR,
        S_KNOB_WR,
        S_AVG,
        S_RESULT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [arbl_pkg::SAMPLE_W-1:0] r_empty_th;
    logic [arbl_pkg::SAMPLE_W-1:0] r_low_th;
    logic [arbl_pkg::SAMPLE_W-1:0] r_plenty_th;
    logic [arbl_pkg::HYST_W-1:0]   r_hyst;

    // ring bookkeeping
    logic [arbl_pkg::PTR_W-1:0]    r_batt_ptr;
    logic [arbl_pkg::PTR_W-1:0]    r_knob_ptr;
    logic [arbl_pkg::IDX_W-1:0]    r_batt_idx;
    logic [arbl_pkg::IDX_W-1:0]    r_knob_idx;
    logic [arbl_pkg::DEPTH-1:0]    r_batt_vld;
    logic [arbl_pkg::SUM_W-1:0]    r_sum;
    logic                          r_phase;
    logic [arbl_pkg::STATUS_W-1:0] r_status;

    // current item
    logic                          r_mode;
    logic [arbl_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_to_knob;
    logic [arbl_pkg::CHAN_W-1:0]   r_chan;
    logic [arbl_pkg::SAMPLE_W-1:0] r_avg;

    // result register
    logic                          r_out_valid;
    logic [arbl_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                          r_out_knob;
    logic [arbl_pkg::CHAN_W-1:0]   r_out_chan;
    logic [arbl_pkg::SAMPLE_W-1:0] r_out_avg;
    logic [arbl_pkg::STATUS_W-1:0] r_out_status;

    logic                          w_accept;
    logic                          w_out_free;
    logic [arbl_pkg::SAMPLE_W-1:0] w_sample;
    logic                          w_to_knob;
    logic [arbl_pkg::CHAN_W-1:0]   w_chan;

    logic                          w_ram_we;
    logic [arbl_pkg::RAM_AW-1:0]   w_ram_waddr;
    logic [arbl_pkg::RAM_AW-1:0]   w_batt_addr;
    logic [arbl_pkg::RAM_AW-1:0]   w_knob_addr;
    logic [arbl_pkg::SAMPLE_W-1:0] w_ram_rdata;
    logic [arbl_pkg::SAMPLE_W-1:0] w_old;

    logic [arbl_pkg::IDX_W-1:0]    n_batt_idx;
    logic [arbl_pkg::IDX_W-1:0]    n_knob_idx;
    logic [arbl_pkg::SUM_W-1:0]    n_sum;
    logic [arbl_pkg::STATUS_W-1:0] n_status;

    logic                          w_avg_start;
    logic                          w_avg_done;
    logic [arbl_pkg::SAMPLE_W-1:0] w_avg;

    // ------------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // sample forming and knob/battery alternation (phase toggles per conversion while adjusting)
    assign w_sample  = arbl_pkg::SAMPLE_W'({i_high_byte, 2'b00})
                     + arbl_pkg::SAMPLE_W'(i_low_byte);
    assign w_to_knob = i_adjusting && r_phase;
    assign w_chan    = !i_adjusting ? arbl_pkg::CH_NONE
                     : (r_phase ? arbl_pkg::CH_BATTERY : arbl_pkg::CH_KNOB);

    // ------------------------------------------------------------------------
    // ring memory: battery slots at the bottom, knob slots above
    // ------------------------------------------------------------------------
    assign w_batt_addr = arbl_pkg::RAM_AW'(r_batt_idx);
    assign w_knob_addr = arbl_pkg::RAM_AW'(arbl_pkg::DEPTH)
                       + arbl_pkg::RAM_AW'(r_knob_idx);
    assign w_ram_we    = (r_state == S_BATT_WR) || (r_state == S_KNOB_WR);
    assign w_ram_waddr = (r_state == S_KNOB_WR) ? w_knob_addr : w_batt_addr;

    // the read port always looks at the battery slot about to be overwritten
    arbl_ram #(
        .W (arbl_pkg::SAMPLE_W),
        .D (arbl_pkg::RAM_D)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (r_sample),
        .i_raddr (w_batt_addr),
        .o_rdata (w_ram_rdata)
    );

    // a battery slot never written reads as zero
    assign w_old = r_batt_vld[r_batt_idx] ? w_ram_rdata : '0;
    assign n_sum = r_sum - arbl_pkg::SUM_W'(w_old) + arbl_pkg::SUM_W'(r_sample);

    // slot index follows pointer mod DEPTH, including the 8-bit pointer wrap
    assign n_batt_idx = ((r_batt_ptr == '1)
                        || (r_batt_idx == arbl_pkg::IDX_W'(arbl_pkg::DEPTH - 1)))
                      ? '0 : r_batt_idx + 1'b1;
    assign n_knob_idx = ((r_knob_ptr == '1)
                        || (r_knob_idx == arbl_pkg::IDX_W'(arbl_pkg::DEPTH - 1)))
                      ? '0 : r_knob_idx + 1'b1;

    // ------------------------------------------------------------------------
    // average of the battery ring
    // ------------------------------------------------------------------------
    assign w_avg_start = w_accept && i_mode;

    arbl_avg u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_avg_start),
        .i_sum   (r_sum),
        .o_done  (w_avg_done),
        .o_avg   (w_avg)
    );

    // ------------------------------------------------------------------------
    // hysteresis classifier: avg < th - h written as avg + h < th, no sign bit
    // ------------------------------------------------------------------------
    always_comb begin
        logic [arbl_pkg::SAMPLE_W:0] v;
        logic [arbl_pkg::SAMPLE_W:0] vh;
        logic [arbl_pkg::SAMPLE_W:0] e;
        logic [arbl_pkg::SAMPLE_W:0] l;
        logic [arbl_pkg::SAMPLE_W:0] p;
        v  = {1'b0, w_avg};
        vh = v + (arbl_pkg::SAMPLE_W + 1)'(r_hyst);
        e  = {1'b0, r_empty_th};
        l  = {1'b0, r_low_th};
        p  = {1'b0, r_plenty_th};
        n_status = r_status;
        if (v < l) begin
            if (v < e) begin
                if (vh < e) begin
                    n_status = arbl_pkg::ST_EMPTY;
                end
            end else begin
                if (vh < l) begin
                    n_status = arbl_pkg::ST_LOW;
                end
            end
        end else begin
            if (v < p) begin
                if (vh < p) begin
                    n_status = arbl_pkg::ST_PLENTY;
                end
            end else begin
                n_status = arbl_pkg::ST_FULL;
            end
        end
    end

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_th  <= arbl_pkg::EMPTY_RST;
            r_low_th    <= arbl_pkg::LOW_RST;
            r_plenty_th <= arbl_pkg::PLENTY_RST;
            r_hyst      <= arbl_pkg::HYST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                arbl_pkg::CFG_EMPTY:  r_empty_th  <= i_cfg_data;
                arbl_pkg::CFG_LOW:    r_low_th    <= i_cfg_data;
                arbl_pkg::CFG_PLENTY: r_plenty_th <= i_cfg_data;
                arbl_pkg::CFG_HYST:   r_hyst      <= i_cfg_data[arbl_pkg::HYST_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // sequencer, ring state and result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_batt_ptr  <= '0;
            r_knob_ptr  <= '0;
            r_batt_idx  <= '0;
            r_knob_idx  <= '0;
            r_batt_vld  <= '0;
            r_sum       <= '0;
            r_phase     <= 1'b0;
            r_status    <= arbl_pkg::ST_PLENTY;
            r_out_valid <= 1'b0;
        end else begin
            // result taken downstream; a new result loads in S_RESULT instead
            if (r_out_valid && !i_out_stall && (r_state != S_RESULT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode    <= i_mode;
                        r_sample  <= i_mode ? '0 : w_sample;
                        r_to_knob <= !i_mode && w_to_knob;
                        r_chan    <= i_mode ? arbl_pkg::CH_NONE : w_chan;
                        r_avg     <= '0;
                        if (!i_mode && i_adjusting) begin
                            r_phase <= !r_phase;
                        end
                        if (i_mode) begin
                            r_state <= S_AVG;
                        end else if (w_to_knob) begin
                            r_state <= S_KNOB_WR;
                        end else begin
                            r_state <= S_BATT_WR;
                        end
                    end
                end
                S_BATT_WR: begin
                    // old slot value arrived from the read issued last cycle
                    r_sum                  <= n_sum;
                    r_batt_vld[r_batt_idx] <= 1'b1;
                    r_batt_ptr             <= r_batt_ptr + 1'b1;
                    r_batt_idx             <= n_batt_idx;
                    r_state                <= S_RESULT;
                end
                S_KNOB_WR: begin
                    r_knob_ptr <= r_knob_ptr + 1'b1;
                    r_knob_idx <= n_knob_idx;
                    r_state    <= S_RESULT;
                end
                S_AVG: begin
                    if (w_avg_done) begin
                        r_avg    <= w_avg;
                        r_status <= n_status;
                        r_state  <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_sample;
                        r_out_knob   <= r_to_knob;
                        r_out_chan   <= r_chan;
                        r_out_avg    <= r_mode ? r_avg : '0;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sample_value    = r_out_sample;
    assign o_went_to_knob    = r_out_knob;
    assign o_next_channel    = r_out_chan;
    assign o_battery_average = r_out_avg;
    assign o_battery_status  = r_out_status;

endmodule

/* rtl/arbl_ram.sv */
// ----------------------------------------------------------------------------
// arbl_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module arbl_ram #(
    parameter int W = 11,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/arbl_avg.sv */
// ----------------------------------------------------------------------------
// arbl_avg
// two stage floor average: running sum times reciprocal, then shift
// ----------------------------------------------------------------------------
module arbl_avg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [arbl_pkg::SUM_W-1:0]     i_sum,
    output logic                           o_done,
    output logic [arbl_pkg::SAMPLE_W-1:0]  o_avg
);

    logic [arbl_pkg::PROD_W-1:0]   r_prod;
    logic [arbl_pkg::SAMPLE_W-1:0] r_avg;
    logic                          r_v1;
    logic                          r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        // exact floor division for every sum that fits the sum width
        r_prod <= arbl_pkg::PROD_W'(i_sum) * arbl_pkg::PROD_W'(arbl_pkg::RECIP_MUL);
        r_avg  <= r_prod[arbl_pkg::RECIP_SHIFT +: arbl_pkg::SAMPLE_W];
    end

    assign o_done = r_v2;
    assign o_avg  = r_avg;

endmodule
